### src/kwmt_pkg.sv
// Shared constants and result type for the k-way merge tournament tree.
package kwmt_pkg;

    // Defaults for the top-level parameters
    localparam int STREAM_COUNT_DEF = 16;
    localparam int KEY_BITS_DEF     = 32;

    // Fixed field widths on the ports
    localparam int KEY_FIELD_BITS    = 32;
    localparam int STREAM_FIELD_BITS = 4;
    localparam int CFG_BITS          = 5;
    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 5'd16;

    // Beat layout
    localparam int S_TDATA_BITS = 32;
    localparam int S_TUSER_BITS = 5;
    localparam int M_TDATA_BITS = 40;
    localparam int M_TUSER_BITS = 2;

    // Bit positions inside the tuser groups
    localparam int S_USER_EOS       = 4;
    localparam int M_USER_ALL_DONE  = 0;
    localparam int M_USER_ORDER_ERR = 1;

    // One result beat before packing
    typedef struct packed {
        logic                         order_error;
        logic                         all_done;
        logic [STREAM_FIELD_BITS-1:0] winner_stream;
        logic [KEY_FIELD_BITS-1:0]    winner_key;
    } result_t;

endpackage

### src/kwmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/kway_merge_tournament_tree_core.sv
// Top level of the k-way merge tournament tree.
// Usage:
//   s_* carries one beat per stream key: the key in tdata, the stream index
//   and an end-of-stream flag in tuser. In the load phase streams come in
//   order 0, 1, ... up to active_streams-1; after the last one the tree is
//   built and the smallest key is emitted on m_*. Afterwards every beat must
//   refill the stream just emitted; one winner beat follows each refill.
//   A beat naming any other stream is dropped and answered by a beat with
//   order_error set. cfg_we/cfg_wdata write active_streams and restart the
//   block in load phase.
// Tree walk:
//   A refill makes one RAM read per tree level on the winner's path, each
//   compare feeding the next level's read, until its result sits in the
//   output register; s_tready is low meanwhile. The build after the last load
//   beat makes two RAM reads per internal node. Error beats and non-final
//   load beats need no tree walk.
// Reset and stall:
//   Reset enters load phase with all streams exhausted and 16 active. The
//   node RAM needs no clearing. The output register holds a result while
//   m_tready is low; the core takes the next beat meanwhile and waits only
//   when a second result is ready before the first has left.
module kway_merge_tournament_tree_core #(
    parameter int STREAM_COUNT = kwmt_pkg::STREAM_COUNT_DEF,
    parameter int KEY_BITS     = kwmt_pkg::KEY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: key[31:0]
    input  logic [kwmt_pkg::S_TDATA_BITS-1:0] s_tdata,
    // tuser: stream_index[3:0], end_of_stream[4]
    input  logic [kwmt_pkg::S_TUSER_BITS-1:0] s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: winner_key[31:0], winner_stream[35:32], zero pad[39:36]
    output logic [kwmt_pkg::M_TDATA_BITS-1:0] m_tdata,
    // tuser: all_done[0], order_error[1]
    output logic [kwmt_pkg::M_TUSER_BITS-1:0] m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [kwmt_pkg::CFG_BITS-1:0]     cfg_wdata
);

    localparam int LEAF_BITS = $clog2(STREAM_COUNT);
    localparam int LEAVES    = 1 << LEAF_BITS;
    localparam int NODE_BITS = LEAF_BITS + 1;
    localparam int SK        = (KEY_BITS < kwmt_pkg::KEY_FIELD_BITS) ?
                               KEY_BITS : kwmt_pkg::KEY_FIELD_BITS;
    localparam int CW        = kwmt_pkg::CFG_BITS;

    // Node entry: winner of a subtree, or a leaf's own key
    typedef struct packed {
        logic                 done;
        logic [SK-1:0]        key;
        logic [LEAF_BITS-1:0] stream;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_BRIGHT,
        ST_BLEFT,
        ST_BCMP,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [NODE_BITS-1:0]  node_reg, node_next;
    entry_t                cur_reg, cur_next;
    entry_t                right_reg, right_next;
    kwmt_pkg::result_t     res_reg, res_next;
    logic                  rd_leaf_reg, rd_leaf_next;
    logic                  rd_done_reg, rd_done_next;
    logic [LEAF_BITS-1:0]  rd_stream_reg, rd_stream_next;
    logic [LEAVES-1:0]     done_reg, done_next;
    logic [CW-1:0]         loaded_reg, loaded_next;
    logic                  running_reg, running_next;
    logic [LEAF_BITS-1:0]  last_winner_reg, last_winner_next;
    logic [CW-1:0]         active_reg, active_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [kwmt_pkg::M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [kwmt_pkg::M_TUSER_BITS-1:0] m_tuser_reg, m_tuser_next;

    logic                  ram_we;
    logic [NODE_BITS-1:0]  ram_waddr;
    entry_t                ram_wdata;
    logic [NODE_BITS-1:0]  ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;

    // a strictly lower than b; exhausted counts above any key
    function automatic logic lower(input entry_t a, input entry_t b);
        return !a.done && (b.done || (a.key < b.key));
    endfunction

    // Result beat for the tree's winner
    function automatic kwmt_pkg::result_t emit(input entry_t w);
        kwmt_pkg::result_t r;
        r.order_error   = 1'b0;
        r.all_done      = w.done;
        r.winner_key    = w.done ? '0 : kwmt_pkg::KEY_FIELD_BITS'(w.key);
        r.winner_stream = w.done ? '0 : kwmt_pkg::STREAM_FIELD_BITS'(w.stream);
        return r;
    endfunction

    kwmt_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (2 * LEAVES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Next-state logic: load, build, replay and output slot
    always_comb
    begin
        logic [kwmt_pkg::STREAM_FIELD_BITS-1:0] idx;
        logic                 eos;
        logic [LEAF_BITS-1:0] leaf;
        logic [CW-1:0]        act_eff;
        logic [CW-1:0]        loaded_inc;
        logic                 idx_ok;
        logic                 out_free;
        logic                 fin;
        kwmt_pkg::result_t    fin_res;
        entry_t               rd_entry;
        entry_t               win;
        logic [NODE_BITS-1:0] parent;

        idx        = s_tuser[kwmt_pkg::STREAM_FIELD_BITS-1:0];
        eos        = s_tuser[kwmt_pkg::S_USER_EOS];
        leaf       = LEAF_BITS'(idx);
        act_eff    = (active_reg == '0) ? CW'(1) : active_reg;
        if (32'(act_eff) > STREAM_COUNT)
        begin
            act_eff = CW'(STREAM_COUNT);
        end
        loaded_inc = loaded_reg + CW'(1);
        idx_ok     = (32'(idx) < LEAVES) &&
                     (32'(idx) == (running_reg ? 32'(last_winner_reg) : 32'(loaded_reg)));
        out_free   = !m_tvalid_reg || m_tready;

        // Read data of the previous cycle; leaves take flag and index from flops
        rd_entry = entry_t'(ram_rdata);
        if (rd_leaf_reg)
        begin
            rd_entry.done   = rd_done_reg;
            rd_entry.stream = rd_stream_reg;
        end

        state_next       = state_reg;
        node_next        = node_reg;
        cur_next         = cur_reg;
        right_next       = right_reg;
        res_next         = res_reg;
        done_next        = done_reg;
        loaded_next      = loaded_reg;
        running_next     = running_reg;
        last_winner_next = last_winner_reg;
        active_next      = active_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;
        fin              = 1'b0;
        fin_res          = '0;
        win              = cur_reg;
        parent           = {1'b0, node_reg[NODE_BITS-1:1]};

        unique case (state_reg)
            ST_IDLE:
            begin
                // Sibling of the incoming leaf, needed at the first level
                ram_raddr = {1'b1, leaf} ^ NODE_BITS'(1);
                if (s_tvalid)
                begin
                    if (!idx_ok)
                    begin
                        fin                 = 1'b1;
                        fin_res.order_error = 1'b1;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = {1'b1, leaf};
                        ram_wdata.done  = eos;
                        ram_wdata.key   = s_tdata[SK-1:0];
                        ram_wdata.stream = leaf;
                        done_next[leaf] = eos;
                        if (running_reg)
                        begin
                            cur_next   = ram_wdata;
                            node_next  = {1'b1, leaf};
                            state_next = ST_RUN;
                        end
                        else
                        begin
                            loaded_next = loaded_inc;
                            if (loaded_inc >= act_eff)
                            begin
                                node_next  = NODE_BITS'(LEAVES - 1);
                                state_next = ST_BRIGHT;
                            end
                        end
                    end
                end
            end

            // One tree level per cycle on the refilled leaf's path
            ST_RUN:
            begin
                win       = lower(rd_entry, cur_reg) ? rd_entry : cur_reg;
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = win;
                cur_next  = win;
                if (parent == NODE_BITS'(1))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    node_next = parent;
                    ram_raddr = parent ^ NODE_BITS'(1);
                end
            end

            // Build: right child first so a fresh parent is never read early
            ST_BRIGHT:
            begin
                ram_raddr  = {node_reg[NODE_BITS-2:0], 1'b1};
                state_next = ST_BLEFT;
            end

            ST_BLEFT:
            begin
                right_next = rd_entry;
                ram_raddr  = {node_reg[NODE_BITS-2:0], 1'b0};
                state_next = ST_BCMP;
            end

            // Build compare: ties go to the right child
            ST_BCMP:
            begin
                win       = lower(rd_entry, right_reg) ? rd_entry : right_reg;
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = win;
                if (node_reg == NODE_BITS'(1))
                begin
                    fin          = 1'b1;
                    running_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    node_next  = node_reg - NODE_BITS'(1);
                    ram_raddr  = {node_next[NODE_BITS-2:0], 1'b1};
                    state_next = ST_BLEFT;
                end
            end

            // Result waits for the output register
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = kwmt_pkg::M_TDATA_BITS'({res_reg.winner_stream,
                                                             res_reg.winner_key});
                    m_tuser_next  = {res_reg.order_error, res_reg.all_done};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Winner result: tree outcome, unless this is an order error
        if (fin)
        begin
            if (!fin_res.order_error)
            begin
                fin_res          = emit(win);
                last_winner_next = win.stream;
            end
            if (out_free)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = kwmt_pkg::M_TDATA_BITS'({fin_res.winner_stream,
                                                         fin_res.winner_key});
                m_tuser_next  = {fin_res.order_error, fin_res.all_done};
                state_next    = ST_IDLE;
            end
            else
            begin
                res_next   = fin_res;
                state_next = ST_OUT;
            end
        end

        // Leaf flag and index travel with the read they belong to
        rd_leaf_next   = ram_raddr[NODE_BITS-1];
        rd_done_next   = done_reg[ram_raddr[LEAF_BITS-1:0]];
        rd_stream_next = ram_raddr[LEAF_BITS-1:0];

        // Register write restarts the block
        if (cfg_we)
        begin
            active_next      = cfg_wdata;
            done_next        = '1;
            loaded_next      = '0;
            running_next     = 1'b0;
            last_winner_next = '0;
        end
    end

    // State, control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= '1;
            loaded_reg      <= '0;
            running_reg     <= 1'b0;
            last_winner_reg <= '0;
            active_reg      <= kwmt_pkg::ACTIVE_RESET;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            loaded_reg      <= loaded_next;
            running_reg     <= running_next;
            last_winner_reg <= last_winner_next;
            active_reg      <= active_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        cur_reg       <= cur_next;
        right_reg     <= right_next;
        res_reg       <= res_next;
        rd_leaf_reg   <= rd_leaf_next;
        rd_done_reg   <= rd_done_next;
        rd_stream_reg <= rd_stream_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

### src/kwmt_checker.sv
// Port-level assertions for the merge core, bound to the top level.
module kwmt_checker #(
    parameter int STREAM_COUNT = kwmt_pkg::STREAM_COUNT_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic [kwmt_pkg::M_TDATA_BITS-1:0] m_tdata,
    input logic [kwmt_pkg::M_TUSER_BITS-1:0] m_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    // A stalled result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Order error beats carry no winner
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[kwmt_pkg::M_USER_ORDER_ERR] |->
            m_tdata == '0 && !m_tuser[kwmt_pkg::M_USER_ALL_DONE])
        else $error("order error beat with winner fields set");

    // Exhausted tree reports zero key and stream
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[kwmt_pkg::M_USER_ALL_DONE] |-> m_tdata == '0)
        else $error("all_done beat with nonzero key or stream");

    // A live winner is always a real stream
    a_stream_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == '0 |-> 32'(m_tdata[35:32]) < STREAM_COUNT)
        else $error("winner stream out of range");

endmodule

bind kway_merge_tournament_tree_core kwmt_checker #(
    .STREAM_COUNT (STREAM_COUNT)
) u_kwmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### sim/tb_kway_merge_tournament_tree_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the k-way merge tournament tree core.
module tb_kway_merge_tournament_tree_core;

    localparam int LEAVES          = 16;
    localparam int DRAIN_CYCLES    = 64;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int KEY_W           = kwmt_pkg::KEY_FIELD_BITS;
    localparam int STREAM_W        = kwmt_pkg::STREAM_FIELD_BITS;
    localparam int CFG_W           = kwmt_pkg::CFG_BITS;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic [kwmt_pkg::S_TDATA_BITS-1:0] s_tdata   = '0;
    logic [kwmt_pkg::S_TUSER_BITS-1:0] s_tuser   = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [kwmt_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic [kwmt_pkg::M_TUSER_BITS-1:0] m_tuser;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [CFG_W-1:0]                  cfg_wdata = '0;

    int tx_idle_pct = 22;
    int rx_idle_pct = 46;

    // run statistics
    int fail_count      = 0;
    int beats_taken     = 0;
    int error_beats     = 0;
    int winners_checked = 0;
    int done_flags      = 0;
    int cfg_writes      = 0;

    // predictor state: one key and one exhausted flag per leaf, branch bits 1..15
    logic [KEY_W-1:0]    tree_key  [LEAVES];
    bit                  tree_done [LEAVES];
    bit                  tree_low  [LEAVES];
    logic [STREAM_W-1:0] tree_last;
    int unsigned         tree_loaded;
    bit                  tree_running;
    logic [CFG_W-1:0]    tree_active;
    kwmt_pkg::result_t   winner_q [$];
    kwmt_pkg::result_t   want;

    kway_merge_tournament_tree_core #(
        .STREAM_COUNT (16),
        .KEY_BITS     (32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned active_count();
        int unsigned a;
        a = 32'(tree_active);
        if (a == 0)
            a = 1;
        if (a > LEAVES)
            a = LEAVES;
        return a;
    endfunction

    // follow the branch bits down to the leaf that wins below this node
    function automatic int unsigned path_winner(input int unsigned node);
        int unsigned n;
        n = node;
        while (n < LEAVES)
            n = 2 * n + tree_low[n];
        return n - LEAVES;
    endfunction

    // exhausted ranks above any key; two exhausted are equal
    function automatic bit ranks_below(input int unsigned a, input int unsigned b);
        if (tree_done[a])
            return 1'b0;
        if (tree_done[b])
            return 1'b1;
        return tree_key[a] < tree_key[b];
    endfunction

    function automatic logic [STREAM_W-1:0] expected_stream();
        return tree_running ? tree_last : tree_loaded[STREAM_W-1:0];
    endfunction

    task automatic tree_restart();
        for (int i = 0; i < LEAVES; i++)
        begin
            tree_key[i]  = '0;
            tree_done[i] = 1'b1;
            tree_low[i]  = 1'b0;
        end
        tree_last    = '0;
        tree_loaded  = 0;
        tree_running = 1'b0;
    endtask

    task automatic tree_emit();
        kwmt_pkg::result_t r;
        int unsigned       w;
        w = path_winner(1);
        tree_last = w[STREAM_W-1:0];
        r = '0;
        if (tree_done[w])
            r.all_done = 1'b1;
        else
        begin
            r.winner_key    = tree_key[w];
            r.winner_stream = w[STREAM_W-1:0];
        end
        winner_q = {winner_q, r};
    endtask

    // apply one accepted input beat and queue what it should produce
    task automatic tree_accept(input logic [STREAM_W-1:0] stream,
                               input logic [KEY_W-1:0] key, input bit eos);
        kwmt_pkg::result_t r;
        int unsigned       node;
        int unsigned       parent;
        int unsigned       other;
        int unsigned       wo;
        int unsigned       cur;
        if (stream != expected_stream())
        begin
            r = '0;
            r.order_error = 1'b1;
            winner_q = {winner_q, r};
            error_beats++;
            return;
        end
        tree_key[stream]  = key;
        tree_done[stream] = eos;
        beats_taken++;
        if (!tree_running)
        begin
            tree_loaded++;
            if (tree_loaded < active_count())
                return;
            // bottom-up build, ties go right
            for (int n = LEAVES - 1; n >= 1; n--)
                tree_low[n] = ranks_below(path_winner(2 * n), path_winner(2 * n + 1)) ? 1'b0
                                                                                      : 1'b1;
            tree_running = 1'b1;
            tree_emit();
            return;
        end
        // replay the refilled leaf's path, ties keep the refilled side
        node = LEAVES + 32'(stream);
        cur  = 32'(stream);
        while (node > 1)
        begin
            parent = node >> 1;
            other  = node ^ 1;
            wo     = path_winner(other);
            if (ranks_below(wo, cur))
            begin
                tree_low[parent] = other[0];
                cur = wo;
            end
            else
                tree_low[parent] = node[0];
            node = parent;
        end
        tree_emit();
    endtask

    // ---------------------------------------------------------------- bus side

    // receiver idles at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (winner_q.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = winner_q.pop_front();
                winners_checked++;
                if (want.all_done)
                    done_flags++;
                if (m_tdata[KEY_W-1:0] !== want.winner_key)
                begin
                    $error("winner_key expected %h actual %h", want.winner_key,
                           m_tdata[KEY_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[KEY_W +: STREAM_W] !== want.winner_stream)
                begin
                    $error("winner_stream expected %0d actual %0d", want.winner_stream,
                           m_tdata[KEY_W +: STREAM_W]);
                    fail_count++;
                end
                if (m_tuser[kwmt_pkg::M_USER_ALL_DONE] !== want.all_done)
                begin
                    $error("all_done expected %b actual %b", want.all_done,
                           m_tuser[kwmt_pkg::M_USER_ALL_DONE]);
                    fail_count++;
                end
                if (m_tuser[kwmt_pkg::M_USER_ORDER_ERR] !== want.order_error)
                begin
                    $error("order_error expected %b actual %b", want.order_error,
                           m_tuser[kwmt_pkg::M_USER_ORDER_ERR]);
                    fail_count++;
                end
            end
        end
    end

    // one input beat, with a random gap ahead of it; returns at the accepting edge
    task automatic send_beat(input logic [STREAM_W-1:0] stream,
                             input logic [KEY_W-1:0] key, input bit eos);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= {eos, stream};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        tree_accept(stream, key, eos);
    endtask

    // beat for some stream other than the one the block waits for
    task automatic send_stray();
        send_beat(STREAM_W'(expected_stream() + $urandom_range(1, 15)), $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    // drop valid, then wait until every result is in
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (winner_q.size() != 0)
            @(posedge clk);
    endtask

    // register write only once the core has gone quiet
    task automatic write_active(input logic [CFG_W-1:0] value);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tree_active = value;
        tree_restart();
        cfg_writes++;
    endtask

    // mix of full-range keys, tie-heavy small keys, extremes and rising runs
    function automatic logic [KEY_W-1:0] pick_key(input logic [3:0] stream);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return tree_key[stream] + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_active();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd1;
            3: return 5'd16;
            4: return CFG_W'($urandom_range(17, 30));
            default: return CFG_W'($urandom_range(2, 15));
        endcase
    endfunction

    // one restart, a full load and a run of refills, with a few stray beats
    task automatic merge_session(input logic [CFG_W-1:0] active);
        int refills;
        write_active(active);
        for (int s = 0; s < active_count(); s++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_stray();
            send_beat(expected_stream(), pick_key(expected_stream()), $urandom_range(0, 9) == 0);
        end
        refills = $urandom_range(8, 40);
        repeat (refills)
        begin
            if ($urandom_range(0, 19) == 0)
                send_stray();
            if ($urandom_range(0, 29) == 0)
                wait_results();
            send_beat(expected_stream(), pick_key(expected_stream()), $urandom_range(0, 6) == 0);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // full 16-stream load straight out of reset, then tie, extreme and stray beats
    task automatic test_reset_load();
        logic [KEY_W-1:0] k;
        for (int s = 0; s < LEAVES; s++)
        begin
            case (s)
                0:       k = 32'hFFFF_FFFF;
                1, 2, 4: k = 32'h0000_0000;
                6, 7:    k = 32'h8000_0000;
                9:       k = 32'h7FFF_FFFF;
                default: k = $urandom;
            endcase
            send_beat(STREAM_W'(s), k, (s == 3) || (s == 14));
        end
        // refill ties the current minimum: refilled side keeps the win
        send_beat(expected_stream(), 32'h0000_0000, 1'b0);
        send_beat(expected_stream(), 32'hFFFF_FFFF, 1'b0);
        send_beat(expected_stream(), $urandom, 1'b1);
        send_stray();
    endtask

    // zero active streams acts as one; exhausting it, then refilling the stream named next
    task automatic test_single_stream();
        write_active(5'd0);
        send_beat(4'd5, $urandom, 1'b0);
        send_beat(4'd0, $urandom, 1'b1);
        send_beat(expected_stream(), 32'h0000_1234, 1'b0);
        send_beat(expected_stream(), 32'h0000_0000, 1'b1);
    endtask

    task automatic test_random_merge(input int tx_pct, input int rx_pct,
                                     input logic [CFG_W-1:0] first_active);
        int goal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = beats_taken + ITEMS_PER_PHASE;
        merge_session(first_active);
        while (beats_taken < goal)
            merge_session(pick_active());
    endtask

    initial
    begin
        tree_active = kwmt_pkg::ACTIVE_RESET;
        tree_restart();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_load();
        test_single_stream();
        test_random_merge(22, 46, 5'd31);
        test_random_merge(46, 22, 5'd1);
        test_random_merge(0, 0, 5'd16);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d key beats and %0d stray beats over %0d register writes",
                 beats_taken, error_beats, cfg_writes);
        $display("checked %0d winner beats, %0d of them with every stream exhausted",
                 winners_checked, done_flags);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### kway_merge_tournament_tree_core.f
src/kwmt_pkg.sv
src/kwmt_ram.sv
src/kway_merge_tournament_tree_core.sv
src/kwmt_checker.sv
sim/tb_kway_merge_tournament_tree_core.sv
